// File: hw/rtl/lspa_pkg.sv
// Shared types, codes and constants for the LED strip pattern animator
`timescale 1ns / 1ps
`default_nettype none

package lspa_pkg;

   // Iterative divider operand widths
   localparam int NUM_W = 25;
   localparam int DEN_W = 16;

   // Command codes
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // Pattern codes
   localparam logic [2:0] PAT_LIGHT    = 3'd0;
   localparam logic [2:0] PAT_BLINK    = 3'd1;
   localparam logic [2:0] PAT_FADE_IN  = 3'd2;
   localparam logic [2:0] PAT_FADE_OUT = 3'd3;
   localparam logic [2:0] PAT_TOGGLE   = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_TIMER_PERIOD = 2'd0;
   localparam logic [1:0] REG_FADE_SPEED   = 2'd1;
   localparam logic [1:0] REG_MAX_BRIGHT   = 2'd2;
   localparam logic [1:0] REG_GRB_ORDER    = 2'd3;

   // Register reset values
   localparam logic [9:0] RST_TIMER_PERIOD = 10'd10;
   localparam logic [7:0] RST_FADE_SPEED   = 8'd1;
   localparam logic [7:0] RST_MAX_BRIGHT   = 8'd255;
   localparam logic       RST_GRB_ORDER    = 1'b1;

   // Result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_POWER = 1'b1;

   // Reciprocal of 100 scaled by 2^31, exact for a phase count below 2^25
   localparam logic [NUM_W-1:0] RECIP_100   = NUM_W'(21474837);
   localparam int               RECIP_SHIFT = 31;

   // Reciprocals of 99 and 100 scaled by 2^20, exact for a level product up to 255*100
   localparam logic [13:0] RECIP_LVL_99  = 14'd10592;
   localparam logic [13:0] RECIP_LVL_100 = 14'd10486;

   // One LED table entry
   typedef struct packed {
      logic [2:0]  pattern;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] period;
      logic [7:0]  min_level;
      logic [7:0]  max_level;
   } entry_type;

   // Entry contents after an all-off command
   localparam entry_type OFF_ENTRY = '{pattern: PAT_LIGHT, red: 8'd0, green: 8'd0,
                                       blue: 8'd0, period: 16'd0, min_level: 8'd0,
                                       max_level: 8'd255};

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

   // Exact x / 255 for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return s[15:8];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lspa_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module lspa_div import lspa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Shift in one numerator bit, subtract where it fits
   always_comb begin
      trial   = {r_ff, q_ff[NUM_W-1]};
      diff    = trial - {1'b0, d_ff};
      ge      = (trial >= {1'b0, d_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = req.num;
         r_in    = '0;
         d_in    = req.den;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         r_in   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/led_strip_pattern_animator.sv
// Set: a divider pass turns the delay into a period, then one power word goes out;
// off emits 3*LED_COUNT+1 words, one a cycle unstalled. Tick: per LED a table read,
// a divider pass for blink, fades and toggle, a wrap and scale of the fade level,
// then three colour words. One command at a time: req_stall is high outside idle.
// Synchronous active-high reset clears the tables (valid flags), counter,
// power state and registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_pattern_animator import lspa_pkg::*; #(
   parameter int LED_COUNT = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [3:0] req_led_index,
   input  wire logic [2:0] req_pattern,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [15:0] req_delay_ms,
   input  wire logic [7:0] req_min_level,
   input  wire logic [7:0] req_max_level,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_power_on,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [9:0] csr_data
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   typedef enum logic [14:0] {
      ST_IDLE     = 15'h0001,
      ST_SET_DIV  = 15'h0002,
      ST_SET_PWR  = 15'h0004,
      ST_RD       = 15'h0008,
      ST_LOAD     = 15'h0010,
      ST_DIV1     = 15'h0020,
      ST_WRAP1    = 15'h0040,
      ST_WRAP2    = 15'h0080,
      ST_SPAN     = 15'h0100,
      ST_LVL      = 15'h0200,
      ST_MUL1     = 15'h0400,
      ST_MUL2     = 15'h0800,
      ST_EMIT     = 15'h1000,
      ST_OFF_EMIT = 15'h2000,
      ST_OFF_PWR  = 15'h4000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] led_ff, led_in;
   logic [1:0]       byte_ff, byte_in;
   logic [15:0]      tick_ff, tick_in;
   logic             power_ff, power_in;
   logic [LED_COUNT-1:0] written_ff, written_in;
   logic [LED_COUNT-1:0] offd_ff, offd_in;
   logic [9:0]       tp_ff;
   logic [7:0]       fs_ff;
   logic [7:0]       mb_ff;
   logic             grb_ff;
   logic [3:0]       set_idx_ff, set_idx_in;
   entry_type        set_ent_ff, set_ent_in;
   entry_type        ent_ff, ent_in;
   logic [7:0]       lvl_ff, lvl_in;
   logic [15:0]      prod_ff, prod_in;
   logic [NUM_W-1:0] phase_ff, phase_in;
   logic [NUM_W-1:0] q100_ff, q100_in;
   logic [7:0]       rem_ff, rem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_power_ff, rsp_power_in;
   logic             rsp_last_ff, rsp_last_in;
   div_req_type      div_req_ff, div_req_in;
   div_rsp_type      div_rsp;

   entry_type        mem [LED_COUNT];
   entry_type        rd_data_ff;
   logic             mem_we;
   entry_type        mem_wdata;

   logic             accept;
   logic             out_free;
   logic             led_last;
   entry_type        cur;
   logic [15:0]      d1;
   logic [7:0]       span;
   logic [7:0]       pfold;
   logic [23:0]      ts;
   logic [7:0]       csel;
   logic [49:0]      wrap_prod;
   logic [NUM_W-1:0] q_sel;
   logic [NUM_W-1:0] rem_w;
   logic [29:0]      lvl_prod;
   logic [7:0]       lvl_q;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign led_last  = (led_ff == IDX_W'(LED_COUNT - 1));
   assign csr_ready = 1'b1;
   assign ts        = tick_ff * fs_ff;

   // Table memory: one write port, registered read at the current LED
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[IDX_W'(set_idx_ff)] <= mem_wdata;
      end
      rd_data_ff <= mem[led_ff];
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff  <= RST_TIMER_PERIOD;
         fs_ff  <= RST_FADE_SPEED;
         mb_ff  <= RST_MAX_BRIGHT;
         grb_ff <= RST_GRB_ORDER;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TIMER_PERIOD: tp_ff  <= csr_data;
            REG_FADE_SPEED:   fs_ff  <= csr_data[7:0];
            REG_MAX_BRIGHT:   mb_ff  <= csr_data[7:0];
            REG_GRB_ORDER:    grb_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Entry being worked on and derived values
   always_comb begin
      if (written_ff[led_ff]) begin
         cur = rd_data_ff;
      end else if (offd_ff[led_ff]) begin
         cur = OFF_ENTRY;
      end else begin
         cur = '0;
      end
      d1   = (cur.period == 16'd0) ? 16'd1 : cur.period;
      span = (ent_ff.max_level >= ent_ff.min_level) ?
             (ent_ff.max_level - ent_ff.min_level) : 8'd0;
      // Wrap the phase count: quotient by 100 from the reciprocal, halved for toggle
      wrap_prod = 50'(phase_ff) * 50'(RECIP_100);
      q_sel = (ent_ff.pattern == PAT_TOGGLE) ? {1'b0, q100_ff[NUM_W-1:1]} : q100_ff;
      rem_w = phase_ff - q_sel * ((ent_ff.pattern == PAT_TOGGLE) ? NUM_W'(200) :
                                                                  NUM_W'(100));
      pfold = rem_ff;
      if (ent_ff.pattern == PAT_TOGGLE && pfold > 8'd100) begin
         pfold = 8'd200 - pfold;
      end
      // Span share of the level: divide by 100 for toggle, by 99 for the fades
      lvl_prod = 30'(prod_ff) * ((ent_ff.pattern == PAT_TOGGLE) ? 30'(RECIP_LVL_100) :
                                                                 30'(RECIP_LVL_99));
      lvl_q = lvl_prod[27:20];
      case (byte_ff)
         2'd0:    csel = grb_ff ? ent_ff.green : ent_ff.red;
         2'd1:    csel = grb_ff ? ent_ff.red : ent_ff.green;
         default: csel = ent_ff.blue;
      endcase
   end

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      led_in       = led_ff;
      byte_in      = byte_ff;
      tick_in      = tick_ff;
      power_in     = power_ff;
      written_in   = written_ff;
      offd_in      = offd_ff;
      set_idx_in   = set_idx_ff;
      set_ent_in   = set_ent_ff;
      ent_in       = ent_ff;
      lvl_in       = lvl_ff;
      prod_in      = prod_ff;
      phase_in     = phase_ff;
      q100_in      = q100_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_power_in = rsp_power_ff;
      rsp_last_in  = rsp_last_ff;
      div_req_in   = div_req_ff;
      div_req_in.start = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = set_ent_ff;
      mem_wdata.period = div_rsp.quot[15:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               led_in  = '0;
               byte_in = 2'd0;
               case (req_cmd)
                  CMD_SET: begin
                     set_idx_in = req_led_index;
                     set_ent_in = '{pattern: req_pattern, red: req_red,
                                    green: req_green, blue: req_blue,
                                    period: 16'd0, min_level: req_min_level,
                                    max_level: req_max_level};
                     div_req_in.start = 1'b1;
                     div_req_in.num   = NUM_W'(req_delay_ms);
                     div_req_in.den   = (tp_ff == 10'd0) ? 16'd1 : DEN_W'(tp_ff);
                     state_in = ST_SET_DIV;
                  end
                  CMD_TICK: state_in = ST_RD;
                  CMD_OFF: begin
                     written_in = '0;
                     offd_in    = '1;
                     state_in   = ST_OFF_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_SET_DIV: begin
            if (div_rsp.done) begin
               if (32'(set_idx_ff) < LED_COUNT) begin
                  mem_we = 1'b1;
                  written_in[IDX_W'(set_idx_ff)] = 1'b1;
               end
               state_in = ST_SET_PWR;
            end
         end
         ST_SET_PWR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_POWER;
               rsp_byte_in  = 8'd0;
               rsp_power_in = 1'b1;
               rsp_last_in  = 1'b1;
               power_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RD: state_in = ST_LOAD;
         ST_LOAD: begin
            ent_in = cur;
            div_req_in.den = d1;
            case (cur.pattern)
               PAT_LIGHT: begin
                  lvl_in   = 8'd255;
                  state_in = ST_MUL1;
               end
               PAT_BLINK: begin
                  div_req_in.start = 1'b1;
                  div_req_in.num   = NUM_W'(tick_ff);
                  state_in = ST_DIV1;
               end
               PAT_FADE_IN, PAT_FADE_OUT: begin
                  div_req_in.start = 1'b1;
                  div_req_in.num   = NUM_W'(ts);
                  state_in = ST_DIV1;
               end
               PAT_TOGGLE: begin
                  div_req_in.start = 1'b1;
                  div_req_in.num   = {ts, 1'b0};
                  state_in = ST_DIV1;
               end
               default: begin
                  lvl_in   = 8'd0;
                  state_in = ST_MUL1;
               end
            endcase
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               if (ent_ff.pattern == PAT_BLINK) begin
                  lvl_in   = div_rsp.quot[0] ? ent_ff.max_level : ent_ff.min_level;
                  state_in = ST_MUL1;
               end else begin
                  phase_in = div_rsp.quot;
                  state_in = ST_WRAP1;
               end
            end
         end
         ST_WRAP1: begin
            q100_in  = NUM_W'(wrap_prod >> RECIP_SHIFT);
            state_in = ST_WRAP2;
         end
         ST_WRAP2: begin
            rem_in   = rem_w[7:0];
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            prod_in  = span * pfold;
            state_in = ST_LVL;
         end
         ST_LVL: begin
            if (ent_ff.pattern == PAT_FADE_OUT) begin
               lvl_in = ent_ff.max_level - lvl_q;
            end else begin
               lvl_in = lvl_q + ent_ff.min_level;
            end
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in  = csel * lvl_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = div255(prod_ff) * mb_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DATA;
               rsp_byte_in  = div255(prod_ff);
               rsp_power_in = power_ff;
               rsp_last_in  = (byte_ff == 2'd2) && led_last;
               if (byte_ff == 2'd2) begin
                  byte_in = 2'd0;
                  if (led_last) begin
                     tick_in  = tick_ff + 16'd1;
                     state_in = ST_IDLE;
                  end else begin
                     led_in   = led_ff + IDX_W'(1);
                     state_in = ST_RD;
                  end
               end else begin
                  byte_in  = byte_ff + 2'd1;
                  state_in = ST_MUL1;
               end
            end
         end
         ST_OFF_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DATA;
               rsp_byte_in  = 8'd0;
               rsp_power_in = power_ff;
               rsp_last_in  = 1'b0;
               if (byte_ff == 2'd2) begin
                  byte_in = 2'd0;
                  led_in  = led_ff + IDX_W'(1);
                  if (led_last) begin
                     state_in = ST_OFF_PWR;
                  end
               end else begin
                  byte_in = byte_ff + 2'd1;
               end
            end
         end
         ST_OFF_PWR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_POWER;
               rsp_byte_in  = 8'd0;
               rsp_power_in = 1'b0;
               rsp_last_in  = 1'b1;
               power_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= 16'd0;
         power_ff     <= 1'b0;
         written_ff   <= '0;
         offd_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         power_ff     <= power_in;
         written_ff   <= written_in;
         offd_ff      <= offd_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
      end
      div_req_ff.num <= div_req_in.num;
      div_req_ff.den <= div_req_in.den;
      led_ff       <= led_in;
      byte_ff      <= byte_in;
      set_idx_ff   <= set_idx_in;
      set_ent_ff   <= set_ent_in;
      ent_ff       <= ent_in;
      lvl_ff       <= lvl_in;
      prod_ff      <= prod_in;
      phase_ff     <= phase_in;
      q100_ff      <= q100_in;
      rem_ff       <= rem_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_power_ff <= rsp_power_in;
      rsp_last_ff  <= rsp_last_in;
   end

   lspa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_data_byte = rsp_byte_ff;
   assign rsp_power_on  = rsp_power_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lspa_chk.sv
// Port-level checks for the LED strip pattern animator and their binding
`timescale 1ns / 1ps
`default_nettype none

module lspa_chk import lspa_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_power_on,
   input wire logic       rsp_last
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte) && $stable(rsp_kind))
      else $error("stalled result word changed");

   // A power update closes its command
   a_pwr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_POWER) |-> rsp_last && (rsp_data_byte == 8'd0))
      else $error("power update not last or carries data");

   // Accepting a set or off makes the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_SET || req_cmd == CMD_OFF) |=> req_stall)
      else $error("command accepted without going busy");

   // A power-off update never directly follows the closing word of a tick frame
   a_set_pwr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_POWER) && !rsp_power_on |->
         !$past(rsp_valid && !rsp_stall && rsp_kind == KIND_DATA && rsp_last))
      else $error("power off follows a tick frame directly");

endmodule

bind led_strip_pattern_animator lspa_chk u_lspa_chk (.*);

`default_nettype wire

// File: tb/sv/tb_led_strip_pattern_animator.sv
// Self-checking testbench for the LED strip pattern animator
`timescale 1ns / 1ps

import lspa_pkg::*;

typedef struct {
   logic       kind;
   logic [7:0] data_byte;
   logic       power_on;
   logic       last;
} strip_word_type;

class strip_scoreboard;
   // predictor state
   logic [2:0]  pat_tbl [16];
   logic [7:0]  red_tbl [16];
   logic [7:0]  grn_tbl [16];
   logic [7:0]  blu_tbl [16];
   logic [15:0] per_tbl [16];
   logic [7:0]  lo_tbl [16];
   logic [7:0]  hi_tbl [16];
   logic [15:0] tick_cnt;
   logic        power;
   logic [9:0]  timer_ms;
   logic [7:0]  fade_mul;
   logic [7:0]  bright_cap;
   logic        grb;
   strip_word_type pending_words[$];
   int          error_count;

   function new();
      for (int i = 0; i < 16; i++) begin
         pat_tbl[i] = '0; red_tbl[i] = '0; grn_tbl[i] = '0; blu_tbl[i] = '0;
         per_tbl[i] = '0; lo_tbl[i] = '0; hi_tbl[i] = '0;
      end
      tick_cnt = '0;
      power = 1'b0;
      timer_ms = RST_TIMER_PERIOD;
      fade_mul = RST_FADE_SPEED;
      bright_cap = RST_MAX_BRIGHT;
      grb = RST_GRB_ORDER;
      error_count = 0;
   endfunction

   function void note_register(logic [1:0] idx, logic [9:0] val);
      case (idx)
         REG_TIMER_PERIOD: timer_ms = val;
         REG_FADE_SPEED:   fade_mul = val[7:0];
         REG_MAX_BRIGHT:   bright_cap = val[7:0];
         REG_GRB_ORDER:    grb = val[0];
         default: ;
      endcase
   endfunction

   function void push_word(logic k, logic [7:0] b, logic p, logic l);
      strip_word_type w;
      w.kind = k; w.data_byte = b; w.power_on = p; w.last = l;
      pending_words.push_back(w);
   endfunction

   function logic [31:0] led_level(int i);
      logic [31:0] d, lo, hi, span, t, p;
      d = (per_tbl[i] != 0) ? per_tbl[i] : 32'd1;
      lo = lo_tbl[i];
      hi = hi_tbl[i];
      span = (hi >= lo) ? hi - lo : 32'd0;
      t = tick_cnt;
      case (pat_tbl[i])
         PAT_LIGHT: return 32'd255;
         PAT_BLINK: return ((t / d) & 1) ? hi : lo;
         PAT_FADE_IN: begin
            p = (t * fade_mul / d) % 100;
            return (span * p / 99 + lo) & 32'hFF;
         end
         PAT_FADE_OUT: begin
            p = (t * fade_mul / d) % 100;
            return (hi - span * p / 99) & 32'hFF;
         end
         PAT_TOGGLE: begin
            p = (t * fade_mul * 2 / d) % 200;
            if (p > 100) p = 200 - p;
            return (span * p / 100 + lo) & 32'hFF;
         end
         default: return 32'd0;
      endcase
   endfunction

   function logic [7:0] scale_colour(logic [7:0] c, logic [31:0] lvl);
      logic [31:0] x;
      x = {24'd0, c} * lvl / 255 * {24'd0, bright_cap} / 255;
      return x[7:0];
   endfunction

   // note an accepted command word and queue its expected output words
   function void note_command(logic [1:0] cmd, logic [3:0] idx, logic [2:0] pat,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [15:0] dly, logic [7:0] lo, logic [7:0] hi);
      logic [31:0] tp, lvl;
      logic [7:0] sr, sg, sb;
      case (cmd)
         CMD_SET: begin
            tp = (timer_ms != 0) ? timer_ms : 32'd1;
            pat_tbl[idx] = pat; red_tbl[idx] = r; grn_tbl[idx] = g;
            blu_tbl[idx] = b; per_tbl[idx] = 16'({16'd0, dly} / tp);
            lo_tbl[idx] = lo; hi_tbl[idx] = hi;
            power = 1'b1;
            push_word(KIND_POWER, 8'd0, 1'b1, 1'b1);
         end
         CMD_TICK: begin
            for (int i = 0; i < 16; i++) begin
               lvl = led_level(i);
               sr = scale_colour(red_tbl[i], lvl);
               sg = scale_colour(grn_tbl[i], lvl);
               sb = scale_colour(blu_tbl[i], lvl);
               push_word(KIND_DATA, grb ? sg : sr, power, 1'b0);
               push_word(KIND_DATA, grb ? sr : sg, power, 1'b0);
               push_word(KIND_DATA, sb, power, i == 15);
            end
            tick_cnt = tick_cnt + 16'd1;
         end
         CMD_OFF: begin
            for (int i = 0; i < 16; i++) begin
               pat_tbl[i] = PAT_LIGHT; red_tbl[i] = '0; grn_tbl[i] = '0;
               blu_tbl[i] = '0; per_tbl[i] = '0; lo_tbl[i] = '0; hi_tbl[i] = 8'd255;
               for (int k = 0; k < 3; k++) push_word(KIND_DATA, 8'd0, power, 1'b0);
            end
            power = 1'b0;
            push_word(KIND_POWER, 8'd0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task report_mismatch(string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   task check_word(strip_word_type got);
      strip_word_type exp_w;
      if (pending_words.size() == 0) begin
         report_mismatch("output word with none expected");
         return;
      end
      exp_w = pending_words.pop_front();
      if (got.kind !== exp_w.kind)
         report_mismatch($sformatf("kind %0b want %0b", got.kind, exp_w.kind));
      if (got.data_byte !== exp_w.data_byte)
         report_mismatch($sformatf("byte %0h want %0h", got.data_byte, exp_w.data_byte));
      if (got.power_on !== exp_w.power_on)
         report_mismatch($sformatf("power %0b want %0b", got.power_on, exp_w.power_on));
      if (got.last !== exp_w.last)
         report_mismatch($sformatf("last %0b want %0b", got.last, exp_w.last));
   endtask
endclass

module tb_led_strip_pattern_animator;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [3:0] req_led_index = '0;
   logic [2:0] req_pattern = '0;
   logic [7:0] req_red = '0, req_green = '0, req_blue = '0;
   logic [15:0] req_delay_ms = '0;
   logic [7:0] req_min_level = '0, req_max_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_kind;
   logic [7:0] rsp_data_byte;
   logic rsp_power_on, rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [9:0] csr_data = '0;

   strip_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;

   led_strip_pattern_animator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_led_strip_pattern_animator: done, errors");
         $finish;
      end
   end

   // sample output words at the rising edge
   always @(posedge clock) begin
      strip_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         w.kind = rsp_kind; w.data_byte = rsp_data_byte;
         w.power_on = rsp_power_on; w.last = rsp_last;
         board.check_word(w);
      end
   end

   // receiver stall: long hold-off first, then random idling
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic write_register(logic [1:0] idx, logic [9:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.note_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // present one command word and hold it until taken
   task automatic send_command(logic [1:0] cmd, logic [3:0] idx, logic [2:0] pat,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [15:0] dly, logic [7:0] lo, logic [7:0] hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_cmd <= cmd; req_led_index <= idx; req_pattern <= pat;
      req_red <= r; req_green <= g; req_blue <= b; req_delay_ms <= dly;
      req_min_level <= lo; req_max_level <= hi;
      do @(posedge clock); while (req_stall);
      board.note_command(cmd, idx, pat, r, g, b, dly, lo, hi);
      @(negedge clock);
   endtask

   task automatic send_random_set(logic [2:0] pat);
      send_command(CMD_SET, 4'($urandom), pat, 8'($urandom), 8'($urandom),
                   8'($urandom), ($urandom_range(3) == 0) ? 16'($urandom) :
                   16'($urandom_range(300)), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_random_item();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) send_random_set(3'($urandom_range(7)));
      else if (sel < 88) send_command(CMD_TICK, 4'($urandom), 3'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom), 16'($urandom),
                                      8'($urandom), 8'($urandom));
      else if (sel < 95) send_command(CMD_OFF, 4'($urandom), 3'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom), 16'($urandom),
                                      8'($urandom), 8'($urandom));
      else send_command(2'd3, 4'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // idle between phases: drain, then let an ignored command settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_words.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every pattern, odd cases
      send_command(CMD_TICK, '0, '0, '0, '0, '0, '0, '0, '0);
      send_command(CMD_SET, 4'd0, PAT_LIGHT, 8'hFF, 8'h00, 8'hAA, 16'hFFFF, 8'h00, 8'hFF);
      send_command(CMD_SET, 4'd1, PAT_BLINK, 8'h55, 8'hFF, 8'hFF, 16'd20, 8'd10, 8'd250);
      send_command(CMD_SET, 4'd2, PAT_FADE_IN, 8'hFF, 8'hFF, 8'hFF, 16'd0, 8'd0, 8'd255);
      send_command(CMD_SET, 4'd3, PAT_FADE_OUT, 8'hFF, 8'h80, 8'h01, 16'd35, 8'd5, 8'd200);
      send_command(CMD_SET, 4'd4, PAT_TOGGLE, 8'hFF, 8'hFF, 8'hFF, 16'd50, 8'd0, 8'd255);
      send_command(CMD_SET, 4'd5, PAT_TOGGLE, 8'h12, 8'h34, 8'h56, 16'd9, 8'd200, 8'd10);
      send_command(CMD_SET, 4'd6, 3'd7, 8'hFF, 8'hFF, 8'hFF, 16'd100, 8'd0, 8'd255);
      send_command(CMD_SET, 4'd15, 3'd5, 8'h7F, 8'h7F, 8'h7F, 16'd1, 8'd255, 8'd255);
      send_command(2'd3, 4'd7, PAT_LIGHT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
      repeat (3) send_command(CMD_TICK, '1, '1, '1, '1, '1, '1, '1, '1);
      send_command(CMD_OFF, '0, '0, '0, '0, '0, '0, '0, '0);
      send_command(CMD_TICK, '0, '0, '0, '0, '0, '0, '0, '0);
      drain();

      // register extremes and zero timer period
      write_register(REG_TIMER_PERIOD, 10'd0);
      write_register(REG_FADE_SPEED, 10'd255);
      write_register(REG_MAX_BRIGHT, 10'd0);
      write_register(REG_GRB_ORDER, 10'd0);
      send_command(CMD_SET, 4'd8, PAT_FADE_IN, 8'hFF, 8'hFF, 8'hFF, 16'd7, 8'd0, 8'd255);
      send_command(CMD_TICK, '0, '0, '0, '0, '0, '0, '0, '0);
      drain();
      write_register(REG_TIMER_PERIOD, 10'd1023);
      write_register(REG_MAX_BRIGHT, 10'd255);
      send_command(CMD_SET, 4'd9, PAT_BLINK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'd255);
      send_command(CMD_TICK, '0, '0, '0, '0, '0, '0, '0, '0);
      drain();

      // long receiver hold-off while commands keep coming
      hold_off_cycles = 3000;
      for (int i = 0; i < 10; i++) send_random_item();
      drain();

      // three idling phases, with register changes between
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 81 : 0;
         recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 17 : 0;
         write_register(REG_TIMER_PERIOD, 10'($urandom_range(1, 1000)));
         write_register(REG_FADE_SPEED, 10'($urandom_range(1, 255)));
         write_register(REG_MAX_BRIGHT, 10'($urandom_range(255)));
         write_register(REG_GRB_ORDER, 10'($urandom_range(1)));
         for (int i = 0; i < 90; i++) begin
            send_random_item();
            if (i == 45) drain();
         end
         drain();
      end

      if (board.error_count == 0) $display("tb_led_strip_pattern_animator: done, clean");
      else $display("tb_led_strip_pattern_animator: done, errors");
      $finish;
   end
endmodule
